// File: hdl/assert_macros.svh
// Assertion helper macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

// File: hdl/ps2m_pkg.sv
package ps2m_pkg;

    localparam logic [7:0] AUX_MASK     = 8'h20;
    localparam logic [1:0] PKT_LAST_POS = 2'd2;
    localparam int         BTN_COUNT    = 3;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [7:0] controller_status;
        logic [7:0] data_byte;
    } ps2m_in_t;

    typedef struct packed {
        ev_kind_t           event_kind;
        logic [1:0]         button_number;
        logic signed [7:0]  move_x;
        logic signed [7:0]  move_y;
        logic               last_event;
    } ps2m_out_t;

    // One completed packet handed from the front end to the event sequencer.
    typedef struct packed {
        logic [7:0]           dx;
        logic [7:0]           dy;
        logic [BTN_COUNT-1:0] btn_new;
        logic [BTN_COUNT-1:0] btn_old;
    } ps2m_job_t;

endpackage

// File: hdl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder. Takes one controller status/data beat per cycle
// while the packet queue has room; beats without the auxiliary status bit, or
// any beat while events_enabled is 0, are dropped. Every third mouse byte
// closes a packet and queues it; the event sequencer then issues 0 to 4 result
// beats (move, then button 1..3 changes), one per cycle unless m_ready stalls
// the output, with last_event on the final one; QUEUE_DEPTH packets can wait
// in between.
module ps2_mouse_packet_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ps2m_pkg::ps2m_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ps2m_pkg::ps2m_out_t m_data
);
    import ps2m_pkg::*;

    ps2m_job_t push_job;
    ps2m_job_t head_job;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    ps2m_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    ps2m_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_job),
        .empty     (q_empty)
    );

    ps2m_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_job   (head_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hdl/ps2m_front.sv
module ps2m_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ps2m_pkg::ps2m_in_t  s_data,
    input  logic                q_full,
    output logic                q_push,
    output ps2m_pkg::ps2m_job_t q_job
);
    import ps2m_pkg::*;

    logic                 en_reg;
    logic [1:0]           pos_reg;
    logic [7:0]           b0_reg;
    logic [7:0]           b1_reg;
    logic [BTN_COUNT-1:0] prev_reg;
    logic                 take;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    assign take   = s_valid && s_ready && en_reg
                    && ((s_data.controller_status & AUX_MASK) != 8'h00);
    assign q_push = take && (pos_reg == PKT_LAST_POS);

    always_comb begin
        q_job.dx      = b1_reg;
        q_job.dy      = s_data.data_byte;
        q_job.btn_new = b0_reg[BTN_COUNT-1:0];
        q_job.btn_old = prev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            pos_reg  <= 2'd0;
            b0_reg   <= 8'h00;
            b1_reg   <= 8'h00;
            prev_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                en_reg <= cfg_data;
            end
            if (take) begin
                if (pos_reg == PKT_LAST_POS) begin
                    pos_reg  <= 2'd0;
                    prev_reg <= b0_reg[BTN_COUNT-1:0];
                end else begin
                    if (pos_reg[0]) begin
                        b1_reg <= s_data.data_byte;
                    end else begin
                        b0_reg <= s_data.data_byte;
                    end
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

endmodule

// File: hdl/ps2m_fifo.sv
module ps2m_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ps2m_pkg::ps2m_job_t push_data,
    output logic                full,
    input  logic                pop,
    output ps2m_pkg::ps2m_job_t pop_data,
    output logic                empty
);
    import ps2m_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ps2m_job_t      slot_reg [DEPTH];
    logic [PW-1:0]  wr_reg;
    logic [PW-1:0]  rd_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// File: hdl/ps2m_back.sv
module ps2m_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ps2m_pkg::ps2m_job_t q_job,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ps2m_pkg::ps2m_out_t m_data
);
    import ps2m_pkg::*;

    // mask bit 0 = move event pending, bit i = button i change pending
    logic [BTN_COUNT:0]   mask_reg, mask_next;
    logic [7:0]           dx_reg;
    logic [7:0]           dy_reg;
    logic [BTN_COUNT-1:0] old_reg;
    logic                 m_valid_reg, m_valid_next;
    ps2m_out_t            m_data_reg, m_data_next;

    logic                 adv;
    logic                 emit;
    logic                 load;
    logic [BTN_COUNT:0]   pick;
    logic [BTN_COUNT:0]   rem;
    logic [BTN_COUNT:0]   job_mask;
    logic [BTN_COUNT-1:0] chg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        chg      = q_job.btn_new ^ q_job.btn_old;
        job_mask = {chg, (q_job.dx != 8'h00) || (q_job.dy != 8'h00)};

        adv  = !m_valid_reg || m_ready;
        emit = adv && (mask_reg != '0);
        pick = mask_reg & (~mask_reg + 1'b1);
        rem  = mask_reg & ~pick;
        load = !q_empty && ((mask_reg == '0) || (emit && (rem == '0)));
        q_pop = load;

        mask_next = mask_reg;
        if (load) begin
            mask_next = job_mask;
        end else if (emit) begin
            mask_next = rem;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_data_next.event_kind    = EV_MOVE;
            m_data_next.button_number = 2'd0;
            m_data_next.move_x        = '0;
            m_data_next.move_y        = '0;
            m_data_next.last_event    = (rem == '0);
            if (pick[0]) begin
                m_data_next.move_x = dx_reg;
                m_data_next.move_y = 8'(8'h00 - dy_reg);
            end else if (pick[1]) begin
                m_data_next.event_kind    = old_reg[0] ? EV_RELEASE : EV_PRESS;
                m_data_next.button_number = 2'd1;
            end else if (pick[2]) begin
                m_data_next.event_kind    = old_reg[1] ? EV_RELEASE : EV_PRESS;
                m_data_next.button_number = 2'd2;
            end else begin
                m_data_next.event_kind    = old_reg[2] ? EV_RELEASE : EV_PRESS;
                m_data_next.button_number = 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dx_reg  <= q_job.dx;
            dy_reg  <= q_job.dy;
            old_reg <= q_job.btn_old;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hdl/ps2m_checker.sv
`include "assert_macros.svh"

module ps2m_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input ps2m_pkg::ps2m_out_t m_data
);
    import ps2m_pkg::*;

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")
    `ASSERT_CLK(a_move_fields, aclk, aresetn, m_valid && (m_data.event_kind == EV_MOVE) |-> (m_data.button_number == 2'd0) && ((m_data.move_x != 8'sd0) || (m_data.move_y != 8'sd0)), "bad move event")
    `ASSERT_CLK(a_button_fields, aclk, aresetn, m_valid && (m_data.event_kind != EV_MOVE) |-> (m_data.button_number != 2'd0) && (m_data.move_x == 8'sd0) && (m_data.move_y == 8'sd0), "bad button event")
    `ASSERT_CLK(a_order, aclk, aresetn, m_valid && m_ready && !m_data.last_event |=> !m_valid || (m_data.event_kind != EV_MOVE), "move event inside a packet")
    `ASSERT_NEVER(a_kind_code, aclk, aresetn, m_valid && (m_data.event_kind != EV_MOVE) && (m_data.event_kind != EV_PRESS) && (m_data.event_kind != EV_RELEASE), "undefined event kind")

endmodule

bind ps2_mouse_packet_decoder ps2m_checker u_ps2m_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/tb_ps2_mouse_packet_decoder.sv
module tb_ps2_mouse_packet_decoder;
    import ps2m_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;

    // Tracks the decoder state and holds the events that are still owed.
    class ps2_event_scoreboard;
        bit                   events_on;
        bit [1:0]             slot;
        bit [7:0]             held_b0;
        bit [7:0]             held_dx;
        bit [BTN_COUNT-1:0]   held_buttons;
        ps2m_out_t            owed_events[$];
        int                   errors;
        int                   events_seen;
        int                   packets_done;
        int                   bytes_taken;

        function void set_enable(bit on);
            events_on = on;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        function void note_beat(ps2m_in_t beat);
            ps2m_out_t burst [4];
            int        n;
            bit [7:0]  neg_dy;
            n = 0;
            if ((beat.controller_status & AUX_MASK) == 8'h00 || !events_on) return;
            bytes_taken++;
            if (slot != PKT_LAST_POS) begin
                if (slot == 2'd0) held_b0 = beat.data_byte;
                else held_dx = beat.data_byte;
                slot++;
                return;
            end
            slot = 2'd0;
            packets_done++;
            if (held_dx != 8'h00 || beat.data_byte != 8'h00) begin
                neg_dy = 8'h00 - beat.data_byte;
                burst[n] = '0;
                burst[n].event_kind = EV_MOVE;
                burst[n].move_x = held_dx;
                burst[n].move_y = neg_dy;
                n++;
            end
            for (int i = 0; i < BTN_COUNT; i++) begin
                if (held_b0[i] != held_buttons[i]) begin
                    burst[n] = '0;
                    burst[n].event_kind = held_buttons[i] ? EV_RELEASE : EV_PRESS;
                    burst[n].button_number = 2'(i + 1);
                    n++;
                end
            end
            // sign/overflow flags in the upper bits are not kept
            held_buttons = held_b0[BTN_COUNT-1:0];
            if (n > 0) burst[n-1].last_event = 1'b1;
            for (int k = 0; k < n; k++) owed_events.push_back(burst[k]);
        endfunction

        task check_event(ps2m_out_t got);
            ps2m_out_t want;
            if (owed_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind=%0d btn=%0d x=%0d y=%0d last=%0b",
                    got.event_kind, got.button_number, got.move_x, got.move_y,
                    got.last_event));
                return;
            end
            want = owed_events.pop_front();
            events_seen++;
            if (got.event_kind !== want.event_kind || got.button_number !== want.button_number
                || got.move_x !== want.move_x || got.move_y !== want.move_y
                || got.last_event !== want.last_event) begin
                report_mismatch($sformatf(
                    "event %0d got kind=%0d btn=%0d x=%0d y=%0d last=%0b, want %0d/%0d/%0d/%0d/%0b",
                    events_seen, got.event_kind, got.button_number, got.move_x, got.move_y,
                    got.last_event, want.event_kind, want.button_number, want.move_x,
                    want.move_y, want.last_event));
            end
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ps2m_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ps2m_out_t m_data;

    ps2_event_scoreboard sb = new;

    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    logic      hold_wanted = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;
    int        stall_cycles = 0;
    ps2m_in_t  directed_beats [20];

    ps2_mouse_packet_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check accepted beats, then pick next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_event(m_data);
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= RX_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(input ps2m_in_t beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_beat(beat);
    endtask

    task automatic write_events_enabled(input bit on);
        cfg_valid <= 1'b1;
        cfg_data <= on;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_enable(on);
        cfg_valid <= 1'b0;
    endtask

    // Quiet packets make no events, so give the block time after the last one.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.owed_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_delta();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return 8'h00;
        if (pick < 40) begin
            case ($urandom_range(3))
                0: return 8'h7F;
                1: return 8'h80;
                2: return 8'h01;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int target);
        int         fed;
        int         span;
        logic [7:0] pkt [3];
        ps2m_in_t   beat;
        fed = 0;
        while (fed < target) begin
            if ($urandom_range(99) < 12) begin
                beat.controller_status = 8'($urandom_range(255)) & ~AUX_MASK;
                beat.data_byte = 8'($urandom_range(255));
                send_beat(beat);
            end else begin
                if ($urandom_range(99) < 25)
                    pkt[0] = {5'($urandom_range(31)), sb.held_buttons};
                else
                    pkt[0] = 8'($urandom_range(255));
                pkt[1] = rand_delta();
                pkt[2] = rand_delta();
                // a cut-short packet throws the byte position out of step
                span = ($urandom_range(99) < 8) ? $urandom_range(2, 1) : 3;
                for (int k = 0; k < span; k++) begin
                    beat.controller_status = 8'($urandom_range(255)) | AUX_MASK;
                    beat.data_byte = pkt[k];
                    send_beat(beat);
                    fed++;
                end
            end
        end
    endtask

    initial begin
        ps2m_in_t beat;
        directed_beats = '{
            {8'hDF, 8'hFF},                                 // no aux bit
            {8'h20, 8'h07}, {8'h20, 8'h7F},
            {8'h00, 8'hAA},                                 // stray byte mid-packet
            {8'hFF, 8'h80},                                 // y = -128 stays -128
            {8'h20, 8'hF8}, {8'h20, 8'h00}, {8'h20, 8'h00}, // all released, flags set
            {8'h20, 8'h00}, {8'h20, 8'h00}, {8'h20, 8'h00}, // quiet packet
            {8'h20, 8'h02}, {8'h20, 8'h80}, {8'h20, 8'hFF},
            {8'h20, 8'h02}, {8'h20, 8'h00}, {8'h20, 8'h01},
            {8'h20, 8'h05}, {8'h20, 8'h01}, {8'h20, 8'h00}
        };
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_events_enabled(1'b0);
        send_beat({AUX_MASK, 8'h09});
        send_beat({8'hFF, 8'h55});
        wait_idle();
        write_events_enabled(1'b1);
        foreach (directed_beats[i]) send_beat(directed_beats[i]);
        wait_idle();

        tx_idle_pct = 24;
        rx_idle_pct <= 85;
        run_phase(100);
        wait_idle();

        write_events_enabled(1'b0);
        for (int i = 0; i < 10; i++) begin
            beat.controller_status = 8'($urandom_range(255)) | AUX_MASK;
            beat.data_byte = 8'($urandom_range(255));
            send_beat(beat);
        end
        wait_idle();
        write_events_enabled(1'b1);

        tx_idle_pct = 85;
        rx_idle_pct <= 24;
        run_phase(100);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_wanted <= 1'b1;
        run_phase(120);
        wait_idle();

        $display("Decoded %0d mouse bytes into %0d packets, %0d events checked,",
            sb.bytes_taken, sb.packets_done, sb.events_seen);
        $display("with events switched off and on and one %0d-cycle result stall.",
            RX_HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
